// ===== rtl/mlfq_pkg.sv =====
`default_nettype none
package mlfq_pkg;

  localparam int TASKS = 16;
  localparam int CORES = 2;
  localparam int TW    = $clog2(TASKS);
  localparam int TCW   = $clog2(TASKS + 1);
  localparam int CW    = (CORES > 1) ? $clog2(CORES) : 1;
  localparam int KW    = 4;

  localparam logic [1:0] ST_READY = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  localparam logic [2:0] OC_IDLE = 3'd0;
  localparam logic [2:0] OC_CONT = 3'd1;
  localparam logic [2:0] OC_FIN  = 3'd2;
  localparam logic [2:0] OC_BLK  = 3'd3;
  localparam logic [2:0] OC_EXP  = 3'd4;

  localparam logic [2:0] CFG_Q0    = 3'd0;
  localparam logic [2:0] CFG_Q1    = 3'd1;
  localparam logic [2:0] CFG_Q2    = 3'd2;
  localparam logic [2:0] CFG_TASKS = 3'd3;
  localparam logic [2:0] CFG_CORES = 3'd4;

  typedef struct packed {
    logic        mode;
    logic [3:0]  task_index;
    logic [15:0] arrival_tick;
    logic [9:0]  burst_length;
    logic [9:0]  io_interval;
    logic [9:0]  io_duration;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  core_index;
    logic        core_busy;
    logic [3:0]  running_task;
    logic [1:0]  ran_level;
    logic [2:0]  outcome;
    logic [15:0] start_tick;
    logic [15:0] finish_tick;
    logic [15:0] tick_now;
    logic        all_done;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] arr;
    logic [9:0]  rem;
    logic [9:0]  every;
    logic [9:0]  iolen;
    logic [1:0]  st;
    logic [1:0]  lvl;
    logic [9:0]  run;
    logic [9:0]  ioleft;
    logic [16:0] first;
  } entry_t;

  typedef struct packed {
    logic        busy;
    logic [3:0]  task_id;
    logic [1:0]  lvl;
    logic [2:0]  outcome;
    logic [15:0] st;
    logic [15:0] ft;
  } res_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_IO, OP_CLR, OP_SCAN, OP_ASSIGN, OP_RUN, OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_IO, S_AS_CHK, S_AS_SCAN, S_AS_SET, S_RUN, S_EMIT
  } state_t;

  typedef struct packed {
    op_t            op;
    logic [TCW-1:0] t;
    logic [KW-1:0]  k;
    logic           last;
    logic           capture;
  } cmd_t;

  typedef struct packed {
    logic [TCW-1:0] n_eff;
    logic [KW-1:0]  c_eff;
    logic [CORES-1:0] core_act;
  } stat_t;

endpackage
`default_nettype wire

// ===== rtl/mlfq_ctrl.sv =====
`default_nettype none
module mlfq_ctrl
  import mlfq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic mode,
  input  wire stat_t stat,
  output logic busy,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic [TCW-1:0] t_r, t_nxt;
  logic [KW-1:0] k_r, k_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      t_r <= '0;
      k_r <= '0;
    end else begin
      state_r <= state_nxt;
      t_r <= t_nxt;
      k_r <= k_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    t_nxt = t_r;
    k_nxt = k_r;
    cmd = '{op: OP_NONE, t: t_r, k: k_r, last: 1'b0, capture: 1'b0};
    busy = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          t_nxt = '0;
          k_nxt = '0;
          if (!mode) state_nxt = S_LOAD;
          else if (stat.n_eff == '0) state_nxt = S_AS_CHK;
          else state_nxt = S_IO;
        end
      end
      S_LOAD: begin
        cmd.op = OP_LOAD;
        state_nxt = S_IDLE;
      end
      S_IO: begin
        cmd.op = OP_IO;
        if (t_r == stat.n_eff - 1'b1) begin
          k_nxt = '0;
          state_nxt = S_AS_CHK;
        end else begin
          t_nxt = t_r + 1'b1;
        end
      end
      S_AS_CHK: begin
        if (k_r >= stat.c_eff) begin
          k_nxt = '0;
          state_nxt = S_RUN;
        end else if (stat.core_act[k_r[CW-1:0]]) begin
          k_nxt = k_r + 1'b1;
        end else begin
          cmd.op = OP_CLR;
          t_nxt = '0;
          state_nxt = (stat.n_eff == '0) ? S_AS_SET : S_AS_SCAN;
        end
      end
      S_AS_SCAN: begin
        cmd.op = OP_SCAN;
        if (t_r == stat.n_eff - 1'b1) state_nxt = S_AS_SET;
        else t_nxt = t_r + 1'b1;
      end
      S_AS_SET: begin
        cmd.op = OP_ASSIGN;
        k_nxt = k_r + 1'b1;
        state_nxt = S_AS_CHK;
      end
      S_RUN: begin
        cmd.op = OP_RUN;
        if (k_r == stat.c_eff - 1'b1) begin
          k_nxt = '0;
          state_nxt = S_EMIT;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_EMIT: begin
        cmd.op = OP_EMIT;
        cmd.last = (k_r == stat.c_eff - 1'b1);
        if (cmd.last) state_nxt = S_IDLE;
        else k_nxt = k_r + 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/mlfq_dp.sv =====
`default_nettype none
module mlfq_dp
  import mlfq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cmd_t      cmd,
  input  wire in_item_t  in_item,
  input  wire logic      cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  output stat_t          stat,
  output logic           out_valid,
  output out_item_t      out_item
);

  logic [7:0] q0_r, q1_r, q2_r;
  logic [4:0] tcnt_r;
  logic [3:0] cores_r;
  in_item_t   in_r;
  entry_t     tasks_r [TASKS];
  logic [15:0] tick_r, tick_nxt;
  logic [4:0]  fin_r, fin_nxt;
  logic [TW-1:0] core_task_r [CORES];
  logic [TW-1:0] core_task_nxt [CORES];
  logic [CORES-1:0] core_act_r, core_act_nxt;
  logic [7:0]  slice_r [CORES];
  logic [7:0]  slice_nxt [CORES];
  res_t        res_r [CORES];
  res_t        res_nxt [CORES];
  logic        found_r, found_nxt;
  logic [TW-1:0] best_r, best_nxt;
  logic [1:0]  bestl_r, bestl_nxt;
  logic        outv_r, outv_nxt;
  out_item_t   out_r, out_nxt;

  logic [TW-1:0] rd_addr;
  entry_t e, ne;
  logic we;
  logic [1:0] lo;
  logic [7:0] sl;
  logic [CW-1:0] kk;

  assign stat.n_eff = (tcnt_r > 5'(TASKS)) ? TCW'(TASKS) : TCW'(tcnt_r);
  assign stat.c_eff = (cores_r == 4'd0) ? 4'd1 :
                      ((cores_r > 4'(CORES)) ? 4'(CORES) : cores_r);
  assign stat.core_act = core_act_r;
  assign out_valid = outv_r;
  assign out_item = out_r;
  assign kk = cmd.k[CW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q0_r <= 8'd2;
      q1_r <= 8'd4;
      q2_r <= 8'd8;
      tcnt_r <= 5'd15;
      cores_r <= 4'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_Q0:    q0_r <= cfg_data;
        CFG_Q1:    q1_r <= cfg_data;
        CFG_Q2:    q2_r <= cfg_data;
        CFG_TASKS: tcnt_r <= cfg_data[4:0];
        CFG_CORES: cores_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) in_r <= in_item;
    if (we) tasks_r[rd_addr] <= ne;
    res_r <= res_nxt;
    found_r <= found_nxt;
    best_r <= best_nxt;
    bestl_r <= bestl_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
      fin_r <= '0;
      core_act_r <= '0;
      outv_r <= 1'b0;
      for (int i = 0; i < CORES; i++) begin
        core_task_r[i] <= '0;
        slice_r[i] <= '0;
      end
    end else begin
      tick_r <= tick_nxt;
      fin_r <= fin_nxt;
      core_act_r <= core_act_nxt;
      outv_r <= outv_nxt;
      core_task_r <= core_task_nxt;
      slice_r <= slice_nxt;
    end
  end

  always_comb begin
    tick_nxt = tick_r;
    fin_nxt = fin_r;
    core_act_nxt = core_act_r;
    core_task_nxt = core_task_r;
    slice_nxt = slice_r;
    res_nxt = res_r;
    found_nxt = found_r;
    best_nxt = best_r;
    bestl_nxt = bestl_r;
    outv_nxt = 1'b0;
    out_nxt = out_r;
    we = 1'b0;
    sl = '0;
    unique case (cmd.op)
      OP_LOAD:          rd_addr = in_r.task_index[TW-1:0];
      OP_IO, OP_SCAN:   rd_addr = cmd.t[TW-1:0];
      OP_ASSIGN:        rd_addr = best_r;
      OP_RUN:           rd_addr = core_task_r[kk];
      default:          rd_addr = '0;
    endcase
    e = tasks_r[rd_addr];
    ne = e;
    lo = (e.lvl > 2'd2) ? 2'd2 : e.lvl;
    unique case (cmd.op)
      OP_LOAD: begin
        for (int i = 0; i < CORES; i++)
          if (core_act_r[i] && core_task_r[i] == rd_addr) core_act_nxt[i] = 1'b0;
        if (e.st == ST_DONE && fin_r != '0) fin_nxt = fin_r - 1'b1;
        ne.arr = in_r.arrival_tick;
        ne.rem = in_r.burst_length;
        ne.every = in_r.io_interval;
        ne.iolen = in_r.io_duration;
        ne.st = ST_READY;
        ne.lvl = 2'd0;
        ne.run = '0;
        ne.ioleft = '0;
        ne.first = 17'h10000;
        we = 1'b1;
      end
      OP_IO: begin
        if (e.st == ST_WAIT) begin
          we = 1'b1;
          if (e.ioleft <= 10'd1) begin
            ne.ioleft = '0;
            ne.st = ST_READY;
            ne.lvl = 2'd0;
            ne.run = '0;
          end else begin
            ne.ioleft = e.ioleft - 1'b1;
          end
        end
      end
      OP_CLR: found_nxt = 1'b0;
      OP_SCAN: begin
        if (e.st == ST_READY && e.arr <= tick_r && (!found_r || lo < bestl_r)) begin
          found_nxt = 1'b1;
          best_nxt = rd_addr;
          bestl_nxt = lo;
        end
      end
      OP_ASSIGN: begin
        if (found_r) begin
          core_task_nxt[kk] = best_r;
          core_act_nxt[kk] = 1'b1;
          priority case (bestl_r)
            2'd0: slice_nxt[kk] = q0_r;
            2'd1: slice_nxt[kk] = q1_r;
            default: slice_nxt[kk] = q2_r;
          endcase
          ne.st = ST_RUN;
          if (e.first[16]) ne.first = {1'b0, tick_r};
          we = 1'b1;
        end
      end
      OP_RUN: begin
        res_nxt[kk] = '0;
        if (core_act_r[kk]) begin
          we = 1'b1;
          res_nxt[kk].busy = 1'b1;
          res_nxt[kk].task_id = 4'(rd_addr);
          res_nxt[kk].lvl = lo;
          ne.run = (e.run == 10'd1023) ? e.run : e.run + 1'b1;
          sl = slice_r[kk] - 1'b1;
          slice_nxt[kk] = sl;
          if (e.rem <= 10'd1) begin
            ne.rem = '0;
            ne.st = ST_DONE;
            fin_nxt = fin_r + 1'b1;
            core_act_nxt[kk] = 1'b0;
            res_nxt[kk].outcome = OC_FIN;
            res_nxt[kk].st = e.first[15:0];
            res_nxt[kk].ft = (tick_r == 16'hFFFF) ? tick_r : tick_r + 1'b1;
          end else begin
            ne.rem = e.rem - 1'b1;
            if (e.every != '0 && ne.run >= e.every) begin
              ne.st = ST_WAIT;
              ne.ioleft = e.iolen;
              core_act_nxt[kk] = 1'b0;
              res_nxt[kk].outcome = OC_BLK;
            end else if (sl == '0) begin
              ne.st = ST_READY;
              if (e.lvl < 2'd2) ne.lvl = e.lvl + 1'b1;
              core_act_nxt[kk] = 1'b0;
              res_nxt[kk].outcome = OC_EXP;
            end else begin
              res_nxt[kk].outcome = OC_CONT;
            end
          end
        end
      end
      OP_EMIT: begin
        outv_nxt = 1'b1;
        out_nxt.core_index = 3'(cmd.k);
        out_nxt.core_busy = res_r[kk].busy;
        out_nxt.running_task = res_r[kk].task_id;
        out_nxt.ran_level = res_r[kk].lvl;
        out_nxt.outcome = res_r[kk].outcome;
        out_nxt.start_tick = res_r[kk].st;
        out_nxt.finish_tick = res_r[kk].ft;
        out_nxt.tick_now = tick_r;
        out_nxt.all_done = (TCW'(fin_r) >= stat.n_eff);
        out_nxt.last = cmd.last;
        if (cmd.last && tick_r != 16'hFFFF) tick_nxt = tick_r + 1'b1;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/multilevel_feedback_queue_scheduler.sv =====
// channel | ports                                   | handshake
// input   | start, busy, in_item                    | taken when start && !busy
// result  | out_valid, out_item                     | one-cycle strobe, no stall
// config  | cfg_we, cfg_index, cfg_data             | written when cfg_we
// Load item: one store write. Tick item: I/O step per task in use; per core
// a check, with a task scan and assignment if idle; run step and result per
// core in use. Results come one per cycle; the last lands the cycle busy drops.
// Reset is synchronous; the task store has no reset and is valid once loaded.
`default_nettype none
module multilevel_feedback_queue_scheduler
  import mlfq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire in_item_t   in_item,
  output logic            out_valid,
  output out_item_t       out_item,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  mlfq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .mode(in_item.mode),
    .stat(stat), .busy(busy), .cmd(cmd)
  );

  mlfq_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_item(in_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .stat(stat), .out_valid(out_valid), .out_item(out_item)
  );

endmodule
`default_nettype wire

// ===== rtl/mlfq_chk.sv =====
`default_nettype none
module mlfq_chk
  import mlfq_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire logic      out_valid,
  input wire out_item_t out_item
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised after accept");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last |=> !out_valid) else $error("result after last");

  a_core_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |=> out_valid &&
      out_item.core_index == $past(out_item.core_index) + 3'd1)
    else $error("core results out of order");

  a_idle_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.core_busy |-> out_item.outcome == OC_IDLE)
    else $error("idle core with outcome");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result after reset");

endmodule

bind multilevel_feedback_queue_scheduler mlfq_chk u_mlfq_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_item(out_item)
);
`default_nettype wire
